// ===== rtl/cpa_pkg.sv =====
package cpa_pkg;

  localparam int NLANE  = 32;
  localparam int ROUNDS = 10;
  localparam int AW     = 5;

  typedef logic [127:0] blk_t;
  typedef logic [NLANE-1:0][127:0] lanes_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_PAD_HIGH = 2'd2;
  localparam logic [1:0] REG_PAD_LOW  = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows; byte i of the state sits at bits 127-8i.
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(i+4*c) -: 8] = SBOX[s[127-8*(i+4*((c+i)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127-32*c -: 8];
      a1  = s[119-32*c -: 8];
      a2  = s[111-32*c -: 8];
      a3  = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // One step of the key schedule: the next round key from the previous one.
  function automatic blk_t key_step(input blk_t rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== rtl/cpa_in_if.sv =====
interface cpa_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] addr_in;

  modport source (output valid, output addr_in, input ready);
  modport sink (input valid, input addr_in, output ready);
endinterface

// ===== rtl/cpa_out_if.sv =====
interface cpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] addr_out;

  modport source (output valid, output addr_out, input ready);
  modport sink (input valid, input addr_out, output ready);
endinterface

// ===== rtl/prefix_preserving_ipv4_anonymizer.sv =====
// Stages from an accepted address to its result: key whitening, ten AES rounds,
// output XOR, each stage a register.
// Throughput: one address per cycle unless out_ch stalls; 32 AES-128 lanes run side by side,
// one per prefix length, and one key schedule step per round stage is shared by them.
// Reset (synchronous, rst high) clears all stage valid bits and sets key and pad to zero.
module prefix_preserving_ipv4_anonymizer (
  input  logic                   clk,
  input  logic                   rst,
  cpa_in_if.sink                 in_ch,
  cpa_out_if.source              out_ch,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [cpa_pkg::AW-1:0] paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  localparam int NST = cpa_pkg::ROUNDS + 1;

  cpa_pkg::blk_t   key, pad;
  logic            v     [NST];
  logic            rdy   [NST+1];
  cpa_pkg::lanes_t lanes [NST];
  cpa_pkg::blk_t   rk    [NST];
  logic [31:0]     addr  [NST];
  cpa_pkg::lanes_t blocks;
  logic [31:0]     otp;

  cpa_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .key, .pad
  );

  // Lane p takes the top p address bits over the pad.
  always_comb begin
    for (int p = 0; p < cpa_pkg::NLANE; p++) begin
      logic [31:0] m;
      m = (p == 0) ? 32'h0 : ~(32'hffffffff >> p);
      blocks[p] = {(in_ch.addr_in & m) | (pad[127:96] & ~m), pad[95:0]};
    end
  end

  // Whitening stage.
  assign rdy[0]      = !v[0] || rdy[1];
  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (rdy[0]) begin
      v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_ch.valid) begin
      for (int p = 0; p < cpa_pkg::NLANE; p++) begin
        lanes[0][p] <= blocks[p] ^ key;
      end
      rk[0]   <= key;
      addr[0] <= in_ch.addr_in;
    end
  end

  // Round stages.
  for (genvar r = 1; r < NST; r++) begin : g_round
    cpa_round #(.ROUND(r)) u_round (
      .clk, .rst,
      .vin(v[r-1]), .rdy_o(rdy[r]),
      .lanes_in(lanes[r-1]), .rk_in(rk[r-1]), .addr_in(addr[r-1]),
      .v(v[r]), .rdy_i(rdy[r+1]),
      .lanes(lanes[r]), .rk(rk[r]), .addr(addr[r])
    );
  end

  // The top ciphertext bit of lane p becomes pad bit 31-p.
  always_comb begin
    for (int p = 0; p < cpa_pkg::NLANE; p++) begin
      otp[31-p] = lanes[NST-1][p][127];
    end
  end

  assign rdy[NST] = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (rdy[NST]) begin
      out_ch.valid <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST] && v[NST-1]) begin
      out_ch.addr_out <= otp ^ addr[NST-1];
    end
  end

endmodule

// ===== rtl/cpa_apb_regs.sv =====
module cpa_apb_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [cpa_pkg::AW-1:0]   paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready,
  output cpa_pkg::blk_t            key,
  output cpa_pkg::blk_t            pad
);

  logic [63:0] key_high, key_low, pad_high, pad_low;
  logic [1:0]  idx;

  assign idx    = paddr[cpa_pkg::AW-1:3];
  assign pready = 1'b1;
  assign key    = {key_high, key_low};
  assign pad    = {pad_high, pad_low};

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      pad_high <= '0;
      pad_low  <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        cpa_pkg::REG_KEY_HIGH: key_high <= pwdata;
        cpa_pkg::REG_KEY_LOW:  key_low  <= pwdata;
        cpa_pkg::REG_PAD_HIGH: pad_high <= pwdata;
        cpa_pkg::REG_PAD_LOW:  pad_low  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (idx)
      cpa_pkg::REG_KEY_HIGH: prdata = key_high;
      cpa_pkg::REG_KEY_LOW:  prdata = key_low;
      cpa_pkg::REG_PAD_HIGH: prdata = pad_high;
      cpa_pkg::REG_PAD_LOW:  prdata = pad_low;
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== rtl/cpa_round.sv =====
module cpa_round #(
  parameter int ROUND = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vin,
  output logic            rdy_o,
  input  cpa_pkg::lanes_t lanes_in,
  input  cpa_pkg::blk_t   rk_in,
  input  logic [31:0]     addr_in,
  output logic            v,
  input  logic            rdy_i,
  output cpa_pkg::lanes_t lanes,
  output cpa_pkg::blk_t   rk,
  output logic [31:0]     addr
);

  cpa_pkg::blk_t   rk_next;
  cpa_pkg::lanes_t lanes_next;

  assign rdy_o = !v || rdy_i;

  // The round key is derived once per transaction and shared by all lanes.
  always_comb begin
    rk_next = cpa_pkg::key_step(rk_in, cpa_pkg::RCON[ROUND-1]);
    for (int p = 0; p < cpa_pkg::NLANE; p++) begin
      if (ROUND == cpa_pkg::ROUNDS) begin
        lanes_next[p] = cpa_pkg::sub_shift(lanes_in[p]) ^ rk_next;
      end else begin
        lanes_next[p] = cpa_pkg::mix_columns(cpa_pkg::sub_shift(lanes_in[p])) ^ rk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy_o) begin
      v <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vin) begin
      lanes <= lanes_next;
      rk    <= rk_next;
      addr  <= addr_in;
    end
  end

`ifndef ASSERT_OFF
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    v && !rdy_i |=> v) else $error("stalled stage lost its transaction");
  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    v && !rdy_i |=> $stable(addr)) else $error("stalled stage changed its address");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    v && rdy_i && !vin |=> !v) else $error("stage repeated a transaction");
`endif

endmodule

// ===== tb/prefix_preserving_ipv4_anonymizer_tb.sv =====
`timescale 1ns / 100ps

module prefix_preserving_ipv4_anonymizer_tb;

  localparam int AW = cpa_pkg::AW;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int N_DIRECTED = 20;

  // Directed addresses: extremes, single set bits at each end, alternating
  // patterns, and neighbours that share long or short prefixes.
  localparam logic [31:0] DIRECTED_ADDRS [N_DIRECTED] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
    32'h7fff_ffff, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555,
    32'hc0a8_0001, 32'hc0a8_0002, 32'hc0a8_0101, 32'h0a00_0001,
    32'h0a00_0000, 32'h0100_0000, 32'h00ff_ff00, 32'hff00_00ff,
    32'h0000_8000, 32'h0001_0000, 32'hc0a8_0001, 32'hfffe_0000
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AW-1:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  cpa_in_if in_ch ();
  cpa_out_if out_ch ();

  prefix_preserving_ipv4_anonymizer DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the configuration registers and the derived round keys.
  logic [63:0] key_hi_m, key_lo_m, pad_hi_m, pad_lo_m;
  logic [7:0] round_key [176];

  logic [31:0] pending_addr_out [$];
  int fail_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  int hold_left;
  logic [31:0] last_addr;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Expands the mirrored key into the eleven round keys.
  function automatic void rebuild_schedule();
    logic [7:0] w [4];
    logic [7:0] first;
    for (int i = 0; i < 8; i++) begin
      round_key[i] = key_hi_m[63-8*i -: 8];
      round_key[8+i] = key_lo_m[63-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = round_key[4*(i-1)+j];
      if (i % 4 == 0) begin
        first = w[0];
        w[0] = cpa_pkg::SBOX[w[1]] ^ cpa_pkg::RCON[i/4-1];
        w[1] = cpa_pkg::SBOX[w[2]];
        w[2] = cpa_pkg::SBOX[w[3]];
        w[3] = cpa_pkg::SBOX[first];
      end
      for (int j = 0; j < 4; j++) round_key[4*i+j] = round_key[4*(i-4)+j] ^ w[j];
    end
  endfunction

  // Encrypts one block and returns the top bit of the first ciphertext byte.
  function automatic logic cipher_top_bit(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ round_key[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = cpa_pkg::SBOX[s[i+4*((c+i)%4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_key[16*r+i];
    end
    return s[0][7];
  endfunction

  // One cipher call per prefix length builds the one-time pad for the address.
  function automatic logic [31:0] anonymize_addr(input logic [31:0] addr);
    logic [31:0] mask, one_time_pad;
    logic [127:0] blk;
    one_time_pad = '0;
    for (int p = 0; p < 32; p++) begin
      mask = (p == 0) ? 32'h0 : (32'hffff_ffff << (32 - p));
      blk = {pad_hi_m, pad_lo_m};
      blk[127:96] = (addr & mask) | (pad_hi_m[63:32] & ~mask);
      one_time_pad[31-p] = cipher_top_bit(blk);
    end
    return one_time_pad ^ addr;
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cpa_pkg::REG_KEY_HIGH: key_hi_m = value;
      cpa_pkg::REG_KEY_LOW:  key_lo_m = value;
      cpa_pkg::REG_PAD_HIGH: pad_hi_m = value;
      cpa_pkg::REG_PAD_LOW:  pad_lo_m = value;
      default: ;
    endcase
    rebuild_schedule();
  endtask

  task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                           input logic [63:0] ph, input logic [63:0] pl);
    reg_write(cpa_pkg::REG_KEY_HIGH, kh);
    reg_write(cpa_pkg::REG_KEY_LOW, kl);
    reg_write(cpa_pkg::REG_PAD_HIGH, ph);
    reg_write(cpa_pkg::REG_PAD_LOW, pl);
  endtask

  // Offers one address, with random idle cycles first, and records its
  // expected anonymized form once the transaction is accepted.
  task automatic send_addr(input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.addr_in <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_addr_out.push_back(anonymize_addr(addr));
    last_addr = addr;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_addr_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random addresses: mostly neighbours of the previous one sharing a random
  // prefix, so that every prefix length is exercised, plus fresh values.
  function automatic logic [31:0] random_addr();
    int cut;
    logic [31:0] keep;
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
      1, 2, 3: return $urandom;
      default: begin
        cut = $urandom_range(32);
        keep = (cut == 0) ? 32'h0 : (32'hffff_ffff << (32 - cut));
        return (last_addr & keep) | ($urandom & ~keep);
      end
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_addr(random_addr());
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_addr_out.size() == 0) begin
        $error("addr_out: no result expected, got %h", out_ch.addr_out);
        fail_count++;
      end else begin
        if (out_ch.addr_out !== pending_addr_out[0]) begin
          $error("addr_out: expected %h, got %h", pending_addr_out[0], out_ch.addr_out);
          fail_count++;
        end
        void'(pending_addr_out.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.addr_in = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    last_addr = '0;
    key_hi_m = '0;
    key_lo_m = '0;
    pad_hi_m = '0;
    pad_lo_m = '0;
    rebuild_schedule();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed addresses under the all-zero reset key and pad.
    for (int i = 0; i < N_DIRECTED; i++) send_addr(DIRECTED_ADDRS[i]);
    drain();

    // The same addresses with every key and pad bit set.
    configure('1, '1, '1, '1);
    for (int i = 0; i < N_DIRECTED; i++) send_addr(DIRECTED_ADDRS[i]);
    drain();

    // Random settings under each idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      configure({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      run_random(200);
      // The sender pauses here until every result is back.
      drain();
      run_random(200);
      drain();
    end

    // Back-pressure: the receiver holds off while addresses keep coming,
    // with key bits cleared and pad bits set as the opposite extreme.
    configure('0, '0, '1, '1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    run_random(200);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
